// ----- hw/rtl/gse_pkg.sv -----
// ----------------------------------------------------------------------------
// gse_pkg
// Shared widths, register map, reset values and helpers of the signed
// Golomb encoder.
// ----------------------------------------------------------------------------
package gse_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int DIVISOR_W = 9;
  localparam int REM_W     = 8;
  localparam int GROUP_W   = 8;
  localparam int COUNT_W   = 4;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;

  localparam int MAX_QUOTIENT_DEFAULT = 255;

  localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 9'd4;
  localparam logic [DIVISOR_W-1:0] DIVISOR_MAX   = 9'd256;
  localparam logic [DIVISOR_W-1:0] DIVISOR_MIN   = 9'd1;

  // Register index, taken from paddr[APB_AW-1:2]
  localparam logic [APB_AW-3:0] REG_DIVISOR = 2'd0;

  // Status of the divider as seen by the sequencer
  typedef struct packed {
    logic                 done;
    logic [SAMPLE_W-1:0]  quotient;
    logic [REM_W-1:0]     remainder;
  } div_status_t;

  // ceil(log2(m)) for m in 1..256
  function automatic logic [COUNT_W-1:0] ceil_log2(input logic [DIVISOR_W-1:0] m);
    logic [COUNT_W-1:0] b;
    b = '0;
    for (int i = 0; i < DIVISOR_W - 1; i++) begin
      if (m > DIVISOR_W'(1 << i)) begin
        b = COUNT_W'(i + 1);
      end
    end
    return b;
  endfunction

endpackage

// ----- hw/rtl/gse_ifs.sv -----
// ----------------------------------------------------------------------------
// gse_sample_if / gse_code_if
// Valid/ready channels of the signed Golomb encoder: samples in, code
// groups out.
// ----------------------------------------------------------------------------
interface gse_sample_if
  import gse_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface gse_code_if
  import gse_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [GROUP_W-1:0] code_bits;
  logic [COUNT_W-1:0] bit_count;
  logic               overflow;
  logic               last_group;

  modport source (output valid, output code_bits, output bit_count,
                  output overflow, output last_group, input ready);
  modport sink   (input valid, input code_bits, input bit_count,
                  input overflow, input last_group, output ready);
endinterface

// ----- hw/rtl/gse_divider.sv -----
// ----------------------------------------------------------------------------
// gse_divider
// Restoring divider, one quotient bit per cycle through a single
// subtract-and-compare unit.
// ----------------------------------------------------------------------------
module gse_divider
  import gse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SAMPLE_W-1:0]  dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output div_status_t          status
);

  localparam int STEP_W = $clog2(SAMPLE_W);

  logic                 busy;
  logic                 done;
  logic [STEP_W-1:0]    step;
  logic [SAMPLE_W-1:0]  dq;
  logic [REM_W-1:0]     rem;
  logic [DIVISOR_W-1:0] dvs;

  logic [DIVISOR_W-1:0] trial;
  logic                 ge;
  logic [DIVISOR_W-1:0] diff;

  assign trial = {rem, dq[SAMPLE_W-1]};
  assign ge    = trial >= dvs;
  assign diff  = trial - dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dq   <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        dq   <= {dq[SAMPLE_W-2:0], ge};
        rem  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        step <= step + STEP_W'(1);
        if (step == STEP_W'(SAMPLE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.done      = done;
  assign status.quotient  = dq;
  assign status.remainder = rem;

endmodule

// ----- hw/rtl/golomb_signed_encoder.sv -----
// ----------------------------------------------------------------------------
// golomb_signed_encoder
// Zigzag-maps a signed sample, divides by the Golomb parameter and emits
// the unary quotient and truncated-binary remainder (or an overflow group) in groups of up to 8 bits.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+------------------------------------
//  samples   | in  | valid / ready    | sample_value[15:0] signed
//  codes     | out | valid / ready    | code_bits[7:0], bit_count[3:0],
//            |     |                  | overflow, last_group
//  APB       | in  | psel / penable   | divisor at byte address 0
//
//  A sample passes the bit-per-cycle divider, a hand-off and a setup step, then q ones, a zero
//  and len remainder bits go out at one code bit per cycle unless held, q being the quotient
//  and len the remainder length; if q exceeds MAX_QUOTIENT, one overflow group goes out instead.
//  A stall on codes holds the bit sequencer only when a bit would close a group or end the code.
//  The last group sits in the output register while the next sample is taken.
//  Reset (rst, synchronous) sets the divisor to 4 and clears the sequencer state, output valid and divider control.
//
module golomb_signed_encoder
  import gse_pkg::*;
#(
  parameter int MAX_QUOTIENT = MAX_QUOTIENT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // streams
  gse_sample_if.sink        samples,
  gse_code_if.source        codes
);

  localparam int QW = $clog2(MAX_QUOTIENT + 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_UNARY = 3'd3;
  localparam logic [2:0] ST_ZERO  = 3'd4;
  localparam logic [2:0] ST_REM   = 3'd5;
  localparam logic [2:0] ST_OVF   = 3'd6;

  localparam logic [2:0] GCNT_FULL = 3'(GROUP_W - 1);

  logic [2:0]           st;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIVISOR_W-1:0] m_eff;
  logic [DIVISOR_W-1:0] m_hold;
  logic [QW-1:0]        qcnt;
  logic [REM_W-1:0]     valsh;
  logic [COUNT_W-1:0]   len;
  logic [COUNT_W-1:0]   rcnt;
  logic [GROUP_W-2:0]   acc;
  logic [2:0]           gcnt;

  logic                 ovalid;
  logic [GROUP_W-1:0]   o_bits;
  logic [COUNT_W-1:0]   o_count;
  logic                 o_ovf;
  logic                 o_last;

  div_status_t          div_stat;
  logic                 div_start;
  logic [SAMPLE_W-1:0]  mapped;

  // --------------------------------------------------------------------------
  // Configuration: one register, written in the APB access phase
  // --------------------------------------------------------------------------
  logic cfg_hit;
  assign cfg_hit = paddr[APB_AW-1:2] == REG_DIVISOR;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? APB_DW'(divisor) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= DIVISOR_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      divisor <= pwdata[DIVISOR_W-1:0];
    end
  end

  // Clamp M to 1..256
  always_comb begin
    priority if (divisor == '0) begin
      m_eff = DIVISOR_MIN;
    end else if (divisor > DIVISOR_MAX) begin
      m_eff = DIVISOR_MAX;
    end else begin
      m_eff = divisor;
    end
  end

  // Zigzag: n >= 0 -> 2n, n < 0 -> -2n-1
  assign mapped = {samples.sample_value[SAMPLE_W-2:0], 1'b0}
                ^ {SAMPLE_W{samples.sample_value[SAMPLE_W-1]}};

  assign samples.ready = st == ST_IDLE;
  assign div_start     = samples.valid && samples.ready;

  gse_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mapped),
    .divisor  (m_eff),
    .status   (div_stat)
  );

  // --------------------------------------------------------------------------
  // Truncated-binary setup: b = ceil(log2 M), u = 2^b - M
  // --------------------------------------------------------------------------
  logic [COUNT_W-1:0]   tb_b;
  logic [DIVISOR_W-1:0] tb_u;
  logic [DIVISOR_W-1:0] rem9;
  logic [DIVISOR_W-1:0] rem_plus_u;
  logic                 tb_short;
  logic [REM_W-1:0]     tb_val;
  logic [COUNT_W-1:0]   tb_len;
  logic                 q_over;

  assign tb_b       = ceil_log2(m_hold);
  assign tb_u       = (DIVISOR_W'(1) << tb_b) - m_hold;
  assign rem9       = {1'b0, div_stat.remainder};
  assign rem_plus_u = rem9 + tb_u;
  assign tb_short   = rem9 < tb_u;
  assign tb_val     = tb_short ? div_stat.remainder : rem_plus_u[REM_W-1:0];
  assign tb_len     = tb_short ? tb_b - COUNT_W'(1) : tb_b;
  assign q_over     = div_stat.quotient > SAMPLE_W'(MAX_QUOTIENT);

  // --------------------------------------------------------------------------
  // Bit sequencer: one code bit per cycle, unless the output holds it, into the group accumulator
  // --------------------------------------------------------------------------
  logic               can_push;
  logic               emitting;
  logic               cur_bit;
  logic               fin;
  logic               grp_full;
  logic               bit_go;
  logic               push_bits;
  logic               push_ovf;
  logic [GROUP_W-1:0] acc_new;
  logic [GROUP_W-1:0] grp_bits;

  assign can_push = !ovalid || codes.ready;
  assign emitting = (st == ST_UNARY) || (st == ST_ZERO) || (st == ST_REM);

  always_comb begin
    unique case (st)
      ST_UNARY: cur_bit = 1'b1;
      ST_REM:   cur_bit = valsh[REM_W-1];
      default:  cur_bit = 1'b0;
    endcase
  end

  assign fin      = ((st == ST_ZERO) && (len == '0))
                 || ((st == ST_REM) && (rcnt == COUNT_W'(1)));
  assign grp_full = gcnt == GCNT_FULL;
  // Hold only when this bit would close a group and the output is busy
  assign bit_go    = emitting && ((!grp_full && !fin) || can_push);
  assign push_bits = bit_go && (grp_full || fin);
  assign push_ovf  = (st == ST_OVF) && can_push;
  assign acc_new   = {acc, cur_bit};
  // Left-align the group: first bit in bit 7, unused low bits zero
  assign grp_bits  = acc_new << (GCNT_FULL - gcnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (div_start) begin
            m_hold <= m_eff;
            st     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            st <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          qcnt  <= div_stat.quotient[QW-1:0];
          len   <= tb_len;
          rcnt  <= tb_len;
          valsh <= tb_val << (COUNT_W'(GROUP_W) - tb_len);
          acc   <= '0;
          gcnt  <= '0;
          priority if (q_over) begin
            st <= ST_OVF;
          end else if (div_stat.quotient == '0) begin
            st <= ST_ZERO;
          end else begin
            st <= ST_UNARY;
          end
        end
        ST_UNARY: begin
          if (bit_go) begin
            qcnt <= qcnt - QW'(1);
            if (qcnt == QW'(1)) begin
              st <= ST_ZERO;
            end
          end
        end
        ST_ZERO: begin
          if (bit_go) begin
            st <= fin ? ST_IDLE : ST_REM;
          end
        end
        ST_REM: begin
          if (bit_go) begin
            valsh <= {valsh[REM_W-2:0], 1'b0};
            rcnt  <= rcnt - COUNT_W'(1);
            if (fin) begin
              st <= ST_IDLE;
            end
          end
        end
        ST_OVF: begin
          if (push_ovf) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase

      // Advance the accumulator on every bit; drop it when a group leaves
      if (bit_go) begin
        if (push_bits) begin
          acc  <= '0;
          gcnt <= '0;
        end else begin
          acc  <= acc_new[GROUP_W-2:0];
          gcnt <= gcnt + 3'd1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (push_bits) begin
      ovalid  <= 1'b1;
      o_bits  <= grp_bits;
      o_count <= {1'b0, gcnt} + COUNT_W'(1);
      o_ovf   <= 1'b0;
      o_last  <= fin;
    end else if (push_ovf) begin
      ovalid  <= 1'b1;
      o_bits  <= '0;
      o_count <= '0;
      o_ovf   <= 1'b1;
      o_last  <= 1'b1;
    end else if (codes.ready) begin
      ovalid <= 1'b0;
    end
  end

  assign codes.valid      = ovalid;
  assign codes.code_bits  = o_bits;
  assign codes.bit_count  = o_count;
  assign codes.overflow   = o_ovf;
  assign codes.last_group = o_last;

endmodule

// ----- hw/rtl/gse_checker.sv -----
// ----------------------------------------------------------------------------
// gse_checker
// Port-level checks of the signed Golomb encoder, bound to the top level.
// ----------------------------------------------------------------------------
module gse_checker
  import gse_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [GROUP_W-1:0] code_bits,
  input logic [COUNT_W-1:0] bit_count,
  input logic               overflow,
  input logic               last_group
);

  // One sample at a time: ready drops right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("encoder ready right after taking a sample");

  // Overflow is a single, empty, final group
  a_overflow_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (bit_count == '0 && last_group && code_bits == '0))
    else $error("malformed overflow group");

  // Groups before the last are full
  a_inner_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_group) |-> (bit_count == COUNT_W'(GROUP_W) && !overflow))
    else $error("non-final group not full");

  // Coded groups carry 1..8 bits, unused low positions zero
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !overflow) |->
      (bit_count != '0 && bit_count <= COUNT_W'(GROUP_W)
       && (code_bits & (8'hFF >> bit_count)) == '0))
    else $error("bad bit count or stray low bits");

  // A stalled group holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(code_bits)
                                   && $stable(bit_count) && $stable(last_group)))
    else $error("output group changed under stall");

endmodule

bind golomb_signed_encoder gse_checker u_gse_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (codes.valid),
  .out_ready  (codes.ready),
  .code_bits  (codes.code_bits),
  .bit_count  (codes.bit_count),
  .overflow   (codes.overflow),
  .last_group (codes.last_group)
);
